// ===== rtl/core/zms_pkg.sv =====
// Shared widths, codes and types of the zero minor scanner.
package zms_pkg;

    localparam int FUNC_W  = 1;
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IW  = 2;
    localparam int ORDER_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_MATRIX_ORDER   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FIRST_ROW_PAIR = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ROW_PAIR_COUNT = 2'd2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;
    localparam logic [CFG_W-1:0]   FIRST_RESET = 7'd0;
    localparam logic [CFG_W-1:0]   COUNT_RESET = 7'd120;

    // Modulus and reciprocal for the exact quotient t / 101 with t below 2^15
    localparam int MUL_W       = 15;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int QUO_W       = 8;
    localparam int MODULUS     = 101;
    localparam int RECIP_K     = 20764;
    localparam int RECIP_SHIFT = 21;

    typedef enum logic [1:0] {
        MUL_AD,
        MUL_BC,
        MUL_RECIP,
        MUL_CHECK
    } mul_op_t;

    typedef struct packed {
        logic    en;
        mul_op_t op;
    } mul_ctrl_t;

endpackage

// ===== rtl/core/zms_if.sv =====
// Handshake channels of the zero minor scanner: items, results, register writes.
interface zms_item_if import zms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [ELEM_W-1:0] element_value;

    modport source (output valid, func, row_index, col_index, element_value, input ready);
    modport sink   (input valid, func, row_index, col_index, element_value, output ready);
endinterface

interface zms_result_if import zms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] row_first;
    logic [IDX_W-1:0] row_second;
    logic [IDX_W-1:0] col_first;
    logic [IDX_W-1:0] col_second;

    modport source (output valid, found, row_first, row_second, col_first, col_second,
                    input ready);
    modport sink   (input valid, found, row_first, row_second, col_first, col_second,
                    output ready);
endinterface

interface zms_cfg_if import zms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/zero_minor_scan_mod_p_core.sv =====
// Top level of the zero 2x2 minor scanner over the integers mod 101.
//
//   channel  dir  payload                                           handshake
//   item     in   func, row_index, col_index, element_value         valid/ready
//   result   out  found, row_first, row_second, col_first, col_second valid/ready
//   cfg      in   index, data                                       valid/ready
//
// For each minor it visits, a find item makes 4 reads on the single RAM read port
// plus one capture, 4 passes through the shared multiplier and one step. A write
// item is followed by the scan restart: S_INIT, then S_WALK, which passes one row
// at a time to reach the first pair and is skipped when the slice is empty.
// Reset and every register write run that same restart; item.ready stays low meanwhile.
// A result waits in the output register; a find item that finishes behind it holds.
module zero_minor_scan_mod_p_core import zms_pkg::*; #(
    parameter int MAX_ORDER = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    zms_item_if.sink   item,
    zms_result_if.source result,
    zms_cfg_if.sink    cfg
);

    localparam int IW        = $clog2(MAX_ORDER);
    localparam int NW        = $clog2(MAX_ORDER + 1);
    localparam int PAIRS_MAX = MAX_ORDER * (MAX_ORDER - 1) / 2;
    localparam int PW        = $clog2(PAIRS_MAX + 1);
    localparam int XW        = (PW > CFG_W) ? PW : CFG_W;
    localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
    localparam int AW        = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_STEP = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [CFG_W-1:0]   first_reg, first_next;
    logic [CFG_W-1:0]   count_reg, count_next;
    logic [IW-1:0]      row_a_reg, row_a_next;
    logic [IW-1:0]      row_b_reg, row_b_next;
    logic [IW-1:0]      col_a_reg, col_a_next;
    logic [IW-1:0]      col_b_reg, col_b_next;
    logic [CFG_W-1:0]   left_reg, left_next;
    logic               done_reg, done_next;
    logic [CFG_W-1:0]   k_reg, k_next;
    logic [2:0]         rd_cnt_reg, rd_cnt_next;
    logic [1:0]         mul_cnt_reg, mul_cnt_next;

    logic [ELEM_W-1:0]  ea_reg, ea_next;
    logic [ELEM_W-1:0]  eb_reg, eb_next;
    logic [ELEM_W-1:0]  ec_reg, ec_next;
    logic [ELEM_W-1:0]  ed_reg, ed_next;

    logic               cand_found_reg, cand_found_next;
    logic [IDX_W-1:0]   cand_rf_reg, cand_rf_next;
    logic [IDX_W-1:0]   cand_rs_reg, cand_rs_next;
    logic [IDX_W-1:0]   cand_cf_reg, cand_cf_next;
    logic [IDX_W-1:0]   cand_cs_reg, cand_cs_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [IDX_W-1:0]   out_rf_reg, out_rf_next;
    logic [IDX_W-1:0]   out_rs_reg, out_rs_next;
    logic [IDX_W-1:0]   out_cf_reg, out_cf_next;
    logic [IDX_W-1:0]   out_cs_reg, out_cs_next;

    logic               item_acc;
    logic               cfg_acc;
    logic [7:0]         order8;
    logic [7:0]         n8;
    logic [NW-1:0]      n;
    logic [2*NW-1:0]    n_prod;
    logic [PW-1:0]      pairs;
    logic [XW-1:0]      avail;
    logic               slice_empty;
    logic [NW-1:0]      span;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ELEM_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ELEM_W-1:0]  ram_rdata;
    logic [IW-1:0]      rd_row;
    logic [IW-1:0]      rd_col;

    mul_ctrl_t          mul_ctrl;
    logic               mul_hit;

    logic [IW-1:0]      adv_row_a, adv_row_b, adv_col_a, adv_col_b;
    logic [CFG_W-1:0]   adv_left;
    logic               adv_done;
    logic [NW-1:0]      cb1, ca1, cb2, rb1, ra1, rb2;

    assign item_acc = item.valid && item.ready;
    assign cfg_acc  = cfg.valid && cfg.ready;

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    // Order in use, limited to 2 .. MAX_ORDER
    assign order8 = 8'(order_reg);
    always_comb
    begin
        priority if (order8 < 8'd2)
        begin
            n8 = 8'd2;
        end
        else if (order8 > 8'(MAX_ORDER))
        begin
            n8 = 8'(MAX_ORDER);
        end
        else
        begin
            n8 = order8;
        end
    end
    assign n = NW'(n8);

    assign n_prod      = (2*NW)'(n) * (2*NW)'(n - NW'(1));
    assign pairs       = PW'(n_prod >> 1);
    assign avail       = XW'(pairs) - XW'(first_reg);
    assign slice_empty = (XW'(first_reg) >= XW'(pairs)) || (count_reg == '0);
    assign span        = n - NW'(1) - NW'(row_a_reg);

    // Next position of the walk, taken when a minor has been tested
    assign cb1 = NW'(col_b_reg) + NW'(1);
    assign ca1 = NW'(col_a_reg) + NW'(1);
    assign cb2 = ca1 + NW'(1);
    assign rb1 = NW'(row_b_reg) + NW'(1);
    assign ra1 = NW'(row_a_reg) + NW'(1);
    assign rb2 = ra1 + NW'(1);

    always_comb
    begin
        adv_row_a = row_a_reg;
        adv_row_b = row_b_reg;
        adv_col_a = col_a_reg;
        adv_col_b = col_b_reg;
        adv_left  = left_reg;
        adv_done  = done_reg;
        priority if (cb1 < n)
        begin
            adv_col_b = IW'(cb1);
        end
        else if (cb2 < n)
        begin
            adv_col_a = IW'(ca1);
            adv_col_b = IW'(cb2);
        end
        else
        begin
            adv_col_a = '0;
            adv_col_b = IW'(1);
            if (left_reg != '0)
            begin
                adv_left = left_reg - CFG_W'(1);
            end
            priority if (left_reg <= CFG_W'(1))
            begin
                adv_done = 1'b1;
            end
            else if (rb1 < n)
            begin
                adv_row_b = IW'(rb1);
            end
            else
            begin
                adv_row_a = IW'(ra1);
                adv_row_b = IW'(rb2);
                if (rb2 >= n)
                begin
                    adv_done = 1'b1;
                end
            end
        end
    end

    // Read order of one minor: a, b, c, d
    always_comb
    begin
        unique case (rd_cnt_reg)
            3'd0:
            begin
                rd_row = row_a_reg;
                rd_col = col_a_reg;
            end
            3'd1:
            begin
                rd_row = row_a_reg;
                rd_col = col_b_reg;
            end
            3'd2:
            begin
                rd_row = row_b_reg;
                rd_col = col_a_reg;
            end
            default:
            begin
                rd_row = row_b_reg;
                rd_col = col_b_reg;
            end
        endcase
    end

    assign ram_raddr = AW'(rd_row) * AW'(MAX_ORDER) + AW'(rd_col);
    assign ram_waddr = AW'(item.row_index) * AW'(MAX_ORDER) + AW'(item.col_index);
    assign ram_wdata = (item.element_value >= ELEM_W'(MODULUS))
                     ? item.element_value - ELEM_W'(MODULUS)
                     : item.element_value;
    assign ram_we    = item_acc && (item.func == FUNC_WRITE)
                     && (8'(item.row_index) < 8'(MAX_ORDER))
                     && (8'(item.col_index) < 8'(MAX_ORDER));

    always_comb
    begin
        state_next      = state_reg;
        order_next      = order_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        row_a_next      = row_a_reg;
        row_b_next      = row_b_reg;
        col_a_next      = col_a_reg;
        col_b_next      = col_b_reg;
        left_next       = left_reg;
        done_next       = done_reg;
        k_next          = k_reg;
        rd_cnt_next     = rd_cnt_reg;
        mul_cnt_next    = mul_cnt_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        ec_next         = ec_reg;
        ed_next         = ed_reg;
        cand_found_next = cand_found_reg;
        cand_rf_next    = cand_rf_reg;
        cand_rs_next    = cand_rs_reg;
        cand_cf_next    = cand_cf_reg;
        cand_cs_next    = cand_cs_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_found_next  = out_found_reg;
        out_rf_next     = out_rf_reg;
        out_rs_next     = out_rs_reg;
        out_cf_next     = out_cf_reg;
        out_cs_next     = out_cs_reg;
        mul_ctrl        = '{en: 1'b0, op: MUL_AD};

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    priority if (item.func == FUNC_WRITE)
                    begin
                        state_next = S_INIT;
                    end
                    else if (done_reg)
                    begin
                        cand_found_next = 1'b0;
                        cand_rf_next    = '0;
                        cand_rs_next    = '0;
                        cand_cf_next    = '0;
                        cand_cs_next    = '0;
                        state_next      = S_PUT;
                    end
                    else
                    begin
                        rd_cnt_next = '0;
                        state_next  = S_READ;
                    end
                end
            end
            S_INIT:
            begin
                col_a_next = '0;
                col_b_next = IW'(1);
                row_a_next = '0;
                row_b_next = IW'(1);
                left_next  = '0;
                done_next  = 1'b1;
                k_next     = first_reg;
                if (slice_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    left_next  = (XW'(count_reg) > avail) ? CFG_W'(avail) : count_reg;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // Skip whole rows until the first pair lies in row a
                if (XW'(k_reg) >= XW'(span))
                begin
                    k_next     = k_reg - CFG_W'(span);
                    row_a_next = row_a_reg + IW'(1);
                end
                else
                begin
                    row_b_next = IW'(XW'(row_a_reg) + XW'(1) + XW'(k_reg));
                    done_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                unique case (rd_cnt_reg)
                    3'd1:    ea_next = ram_rdata;
                    3'd2:    eb_next = ram_rdata;
                    3'd3:    ec_next = ram_rdata;
                    3'd4:    ed_next = ram_rdata;
                    default: ;
                endcase
                if (rd_cnt_reg == 3'd4)
                begin
                    mul_cnt_next = '0;
                    state_next   = S_MUL;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 3'd1;
                end
            end
            S_MUL:
            begin
                mul_ctrl.en = 1'b1;
                unique case (mul_cnt_reg)
                    2'd0:    mul_ctrl.op = MUL_AD;
                    2'd1:    mul_ctrl.op = MUL_BC;
                    2'd2:    mul_ctrl.op = MUL_RECIP;
                    default: mul_ctrl.op = MUL_CHECK;
                endcase
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    mul_cnt_next = mul_cnt_reg + 2'd1;
                end
            end
            S_STEP:
            begin
                row_a_next = adv_row_a;
                row_b_next = adv_row_b;
                col_a_next = adv_col_a;
                col_b_next = adv_col_b;
                left_next  = adv_left;
                done_next  = adv_done;
                priority if (mul_hit)
                begin
                    cand_found_next = 1'b1;
                    cand_rf_next    = IDX_W'(row_a_reg);
                    cand_rs_next    = IDX_W'(row_b_reg);
                    cand_cf_next    = IDX_W'(col_a_reg);
                    cand_cs_next    = IDX_W'(col_b_reg);
                    state_next      = S_PUT;
                end
                else if (adv_done)
                begin
                    cand_found_next = 1'b0;
                    cand_rf_next    = '0;
                    cand_rs_next    = '0;
                    cand_cf_next    = '0;
                    cand_cs_next    = '0;
                    state_next      = S_PUT;
                end
                else
                begin
                    rd_cnt_next = '0;
                    state_next  = S_READ;
                end
            end
            S_PUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = cand_found_reg;
                    out_rf_next    = cand_rf_reg;
                    out_rs_next    = cand_rs_reg;
                    out_cf_next    = cand_cf_reg;
                    out_cs_next    = cand_cs_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Any register write restarts the scan with the new values
        if (cfg_acc)
        begin
            unique case (cfg.index)
                CFG_MATRIX_ORDER:
                begin
                    order_next = cfg.data[ORDER_W-1:0];
                    state_next = S_INIT;
                end
                CFG_FIRST_ROW_PAIR:
                begin
                    first_next = cfg.data;
                    state_next = S_INIT;
                end
                CFG_ROW_PAIR_COUNT:
                begin
                    count_next = cfg.data;
                    state_next = S_INIT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            order_reg     <= ORDER_RESET;
            first_reg     <= FIRST_RESET;
            count_reg     <= COUNT_RESET;
            row_a_reg     <= '0;
            row_b_reg     <= IW'(1);
            col_a_reg     <= '0;
            col_b_reg     <= IW'(1);
            left_reg      <= COUNT_RESET;
            done_reg      <= 1'b0;
            k_reg         <= '0;
            rd_cnt_reg    <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            row_a_reg     <= row_a_next;
            row_b_reg     <= row_b_next;
            col_a_reg     <= col_a_next;
            col_b_reg     <= col_b_next;
            left_reg      <= left_next;
            done_reg      <= done_next;
            k_reg         <= k_next;
            rd_cnt_reg    <= rd_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg         <= ea_next;
        eb_reg         <= eb_next;
        ec_reg         <= ec_next;
        ed_reg         <= ed_next;
        cand_found_reg <= cand_found_next;
        cand_rf_reg    <= cand_rf_next;
        cand_rs_reg    <= cand_rs_next;
        cand_cf_reg    <= cand_cf_next;
        cand_cs_reg    <= cand_cs_next;
        out_found_reg  <= out_found_next;
        out_rf_reg     <= out_rf_next;
        out_rs_reg     <= out_rs_next;
        out_cf_reg     <= out_cf_next;
        out_cs_reg     <= out_cs_next;
    end

    zms_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    zms_mul_unit u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mul_ctrl),
        .elem_a (ea_reg),
        .elem_b (eb_reg),
        .elem_c (ec_reg),
        .elem_d (ed_reg),
        .hit    (mul_hit)
    );

    assign result.valid      = out_valid_reg;
    assign result.found      = out_found_reg;
    assign result.row_first  = out_rf_reg;
    assign result.row_second = out_rs_reg;
    assign result.col_first  = out_cf_reg;
    assign result.col_second = out_cs_reg;

endmodule

// ===== rtl/core/zms_ram.sv =====
// Generic single write, single read RAM with registered read data.
module zms_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/zms_mul_unit.sv =====
// Shared multiplier that tests a 2x2 determinant for zero mod 101 in four passes.
module zms_mul_unit import zms_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  mul_ctrl_t         ctrl,
    input  logic [ELEM_W-1:0] elem_a,
    input  logic [ELEM_W-1:0] elem_b,
    input  logic [ELEM_W-1:0] elem_c,
    input  logic [ELEM_W-1:0] elem_d,
    output logic              hit
);

    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [MUL_W-1:0]  t_reg;
    logic [MUL_W-1:0]  t_next;
    logic [QUO_W-1:0]  q_reg;
    logic [QUO_W-1:0]  q_next;
    logic              hit_reg;
    logic              hit_next;

    // t = a*d + (101-b)*c is congruent to ad - bc; its quotient comes from the reciprocal
    always_comb
    begin
        unique case (ctrl.op)
            MUL_AD:
            begin
                mul_a = MUL_W'(elem_a);
                mul_b = MUL_W'(elem_d);
            end
            MUL_BC:
            begin
                mul_a = MUL_W'(MODULUS) - MUL_W'(elem_b);
                mul_b = MUL_W'(elem_c);
            end
            MUL_RECIP:
            begin
                mul_a = t_reg;
                mul_b = MUL_W'(RECIP_K);
            end
            MUL_CHECK:
            begin
                mul_a = MUL_W'(q_reg);
                mul_b = MUL_W'(MODULUS);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        t_next   = t_reg;
        q_next   = q_reg;
        hit_next = hit_reg;
        if (ctrl.en)
        begin
            unique case (ctrl.op)
                MUL_AD:    t_next   = prod[MUL_W-1:0];
                MUL_BC:    t_next   = t_reg + prod[MUL_W-1:0];
                MUL_RECIP: q_next   = prod[RECIP_SHIFT +: QUO_W];
                MUL_CHECK: hit_next = (prod[MUL_W-1:0] == t_reg);
                default:   hit_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule
